### hw/rtl/wwoc_pkg.sv
// ----------------------------------------------------------------------------
// wwoc_pkg
// Shared constants, types and the delimiter decode for the whole-word
// occurrence counter.
// ----------------------------------------------------------------------------
`default_nettype none

package wwoc_pkg;

  // Default parameter values
  localparam int DEF_MAX_WORD_LEN = 16;
  localparam int DEF_COUNT_BITS   = 32;

  // Fixed field widths
  localparam int BYTE_W     = 8;
  localparam int WORD_LEN_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int OCC_W      = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN = 2'd2;

  // Special byte codes
  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;

  // One staged text beat handed to the scanner
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] text_byte;
    logic              eot;
  } step_t;

  // Token delimiter set
  function automatic logic is_delim(input logic [BYTE_W-1:0] b);
    logic hit;
    hit = 1'b0;
    case (b)
      8'h20, 8'h09, 8'h0A, 8'h2C, 8'h3B, 8'h2E, 8'h3D, 8'h22,
      8'h28, 8'h29, 8'h5F, 8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h21,
      8'h3F, 8'h26, 8'h2D, 8'h24, 8'h2A, 8'h2B, 8'h3A: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/wwoc_scan.sv
// ----------------------------------------------------------------------------
// wwoc_scan
// Token tracker and match counter: consumes one staged text byte per cycle while step.vld is set.
// ----------------------------------------------------------------------------
`default_nettype none

module wwoc_scan #(
  parameter int MAX_WORD_LEN = wwoc_pkg::DEF_MAX_WORD_LEN,
  parameter int COUNT_BITS   = wwoc_pkg::DEF_COUNT_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire wwoc_pkg::step_t                        step,
  input  wire logic [wwoc_pkg::CFG_DATA_W-1:0]        word_lo,
  input  wire logic [wwoc_pkg::CFG_DATA_W-1:0]        word_hi,
  input  wire logic [wwoc_pkg::WORD_LEN_W-1:0]        word_len,
  output logic      [COUNT_BITS-1:0]                  fin_count
);
  import wwoc_pkg::*;

  localparam int POS_W = $clog2(MAX_WORD_LEN + 1);
  localparam logic [WORD_LEN_W-1:0] MAX_LEN = WORD_LEN_W'(MAX_WORD_LEN);

  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  tok_r, tok_nxt;
  logic                  mat_r, mat_nxt;
  logic                  skip_r, skip_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [2*CFG_DATA_W-1:0] word;
  logic                    len_ok;
  logic                    hit1, hit2;
  logic [POS_W-1:0]        p;
  logic                    m;
  logic [3:0]              bidx;
  logic [BYTE_W-1:0]       wbyte;
  logic [POS_W-1:0]        pos_s;
  logic                    tok_s, mat_s, skip_s;
  logic [COUNT_BITS-1:0]   cnt_a;

  assign word   = {word_hi, word_lo};
  assign len_ok = (word_len != '0) && (word_len <= MAX_LEN);
  assign p      = tok_r ? pos_r : '0;
  assign m      = tok_r ? mat_r : 1'b1;
  assign bidx   = 4'(p);
  assign wbyte  = word[{bidx, 3'b000} +: BYTE_W];

  // Closing the current open token
  assign hit1 = tok_r && mat_r && len_ok && (WORD_LEN_W'(pos_r) == word_len);

  always_comb begin
    pos_s  = pos_r;
    tok_s  = tok_r;
    mat_s  = mat_r;
    skip_s = skip_r;
    cnt_a  = cnt_r;
    if (skip_r) begin
      if (step.text_byte == CH_NL) begin
        skip_s = 1'b0;
      end
    end else if (step.text_byte == CH_NUL || is_delim(step.text_byte)) begin
      if (hit1 && cnt_r != '1) begin
        cnt_a = cnt_r + 1'b1;
      end
      tok_s  = 1'b0;
      mat_s  = 1'b0;
      pos_s  = '0;
      skip_s = (step.text_byte == CH_NUL);
    end else begin
      tok_s = 1'b1;
      pos_s = p;
      mat_s = m;
      if (m) begin
        if (WORD_LEN_W'(p) < word_len && WORD_LEN_W'(p) < MAX_LEN &&
            wbyte == step.text_byte) begin
          pos_s = p + 1'b1;
        end else begin
          mat_s = 1'b0;
        end
      end
    end
  end

  // End of text closes whatever token is still open
  assign hit2 = tok_s && mat_s && len_ok && (WORD_LEN_W'(pos_s) == word_len);
  assign fin_count = (hit2 && cnt_a != '1) ? cnt_a + 1'b1 : cnt_a;

  always_comb begin
    pos_nxt  = pos_r;
    tok_nxt  = tok_r;
    mat_nxt  = mat_r;
    skip_nxt = skip_r;
    cnt_nxt  = cnt_r;
    if (step.vld) begin
      if (step.eot) begin
        pos_nxt  = '0;
        tok_nxt  = 1'b0;
        mat_nxt  = 1'b0;
        skip_nxt = 1'b0;
        cnt_nxt  = '0;
      end else begin
        pos_nxt  = pos_s;
        tok_nxt  = tok_s;
        mat_nxt  = mat_s;
        skip_nxt = skip_s;
        cnt_nxt  = cnt_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tok_r  <= 1'b0;
      mat_r  <= 1'b0;
      skip_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      tok_r  <= tok_nxt;
      mat_r  <= mat_nxt;
      skip_r <= skip_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/whole_word_occurrence_counter_top.sv
// ----------------------------------------------------------------------------
// whole_word_occurrence_counter_top
// Counts tokens in a byte stream that equal a configured search word.
// ----------------------------------------------------------------------------
// The block takes one text byte per beat and sustains one byte per clock
// unless an end_of_text byte meets a previous result that is still waiting.
// A byte lands in an input register and is scanned there against the search
// word; the end_of_text byte loads the result register. Tokens are
// split on space, tab, newline and , ; . = " ( ) _ { } < > ! ? & - $ * + :.
// A token counts only when its length equals word_length and every byte
// agrees; a word length of zero or above MAX_WORD_LEN never matches. A zero
// byte closes the open token and drops the rest of its line through the next
// newline. After a result, all counting state returns to zero for the next
// stream. Write the search word registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module whole_word_occurrence_counter_top #(
  parameter int MAX_WORD_LEN = wwoc_pkg::DEF_MAX_WORD_LEN,
  parameter int COUNT_BITS   = wwoc_pkg::DEF_COUNT_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Text input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [wwoc_pkg::BYTE_W-1:0]        in_text_byte,
  input  wire logic                               in_end_of_text,
  // Result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [wwoc_pkg::OCC_W-1:0]         out_occurrences,
  output logic                                    out_found,
  // Configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [wwoc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wwoc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wwoc_pkg::*;

  // Configuration registers
  logic [CFG_DATA_W-1:0] word_lo_r, word_hi_r;
  logic [WORD_LEN_W-1:0] word_len_r;

  // Input stage
  logic                  stg_vld_r, stg_vld_nxt;
  logic [BYTE_W-1:0]     stg_byte_r;
  logic                  stg_eot_r;

  // Result register
  logic                  out_vld_r, out_vld_nxt;
  logic [OCC_W-1:0]      out_occ_r;
  logic                  out_fnd_r;

  logic                  adv;
  logic                  in_acc;
  step_t                 step;
  logic [COUNT_BITS-1:0] fin_count;
  logic [OCC_W-1:0]      occ_sat;

  // Hold the staged byte only when it ends a stream and the previous result
  // is still waiting; any other byte advances at once.
  assign adv      = stg_vld_r && !(stg_eot_r && out_vld_r && out_stall);
  assign in_stall = stg_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_lo_r  <= '0;
      word_hi_r  <= '0;
      word_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WORD_LO:  word_lo_r  <= cfg_data;
        CFG_WORD_HI:  word_hi_r  <= cfg_data;
        CFG_WORD_LEN: word_len_r <= cfg_data[WORD_LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  // Input stage: refill whenever the staged beat moves on or the stage is empty
  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_acc) begin
      stg_vld_nxt = 1'b1;
    end else if (adv) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_text_byte;
      stg_eot_r  <= in_end_of_text;
    end
  end

  assign step.vld       = adv;
  assign step.text_byte = stg_byte_r;
  assign step.eot       = stg_eot_r;

  wwoc_scan #(
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .COUNT_BITS   (COUNT_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word_lo   (word_lo_r),
    .word_hi   (word_hi_r),
    .word_len  (word_len_r),
    .fin_count (fin_count)
  );

  // Clamp a wider count to the 32-bit result field
  always_comb begin
    occ_sat = OCC_W'(fin_count);
    if (COUNT_BITS > OCC_W && (fin_count >> OCC_W) != '0) begin
      occ_sat = '1;
    end
  end

  // Result register: load on end of text, drop once taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv && stg_eot_r) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && stg_eot_r) begin
      out_occ_r <= occ_sat;
      out_fnd_r <= (fin_count != '0);
    end
  end

  assign out_valid       = out_vld_r;
  assign out_occurrences = out_occ_r;
  assign out_found       = out_fnd_r;

endmodule

`default_nettype wire

### hw/rtl/wwoc_checker.sv
// ----------------------------------------------------------------------------
// wwoc_checker
// Port-level checks on the whole-word occurrence counter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module wwoc_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic [wwoc_pkg::BYTE_W-1:0]     in_text_byte,
  input wire logic                            in_end_of_text,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [wwoc_pkg::OCC_W-1:0]      out_occurrences,
  input wire logic                            out_found
);

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input backs up only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with result side free");

  // A stalled text beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=>
      (in_valid && $stable(in_text_byte) && $stable(in_end_of_text)))
    else $error("stalled text beat changed");

  // Found flag agrees with the count
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found == (out_occurrences != '0)))
    else $error("found flag disagrees with count");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_occurrences) && $stable(out_found)))
    else $error("stalled result changed");

endmodule

bind whole_word_occurrence_counter_top wwoc_checker u_wwoc_checker (.*);

`default_nettype wire
